>>> design/cisc_pkg.sv
// Shared types, constants, arithmetic helpers and the microcode ROM for the
// console input stage colorer. No dependencies; every other file imports this.
package cisc_pkg;

	// Widths
	localparam int SAMPLE_W       = 24;
	localparam int COEF_FRAC_BITS = 28;
	localparam int CFG_ADDR_W     = 5;
	localparam int PC_W           = 6;
	localparam int MA_W           = 33;
	localparam int MB_W           = 32;
	localparam int PROD_W         = MA_W + MB_W;
	localparam int ACC_W          = 68;

	// Highpass amounts (Q0.32) and soft-saturation gain (0.1768 in Q0.32)
	localparam logic signed [MB_W-1:0] HPF_FRONT_AMT = 32'sd7992363;
	localparam logic signed [MB_W-1:0] HPF_BACK_AMT  = 32'sd1234786;
	localparam logic signed [MB_W-1:0] SOFT_K        = 32'sd759350218;
	localparam logic signed [24:0]     ONE_Q23       = 25'sd8388608;

	// Register reset values
	localparam logic [22:0]        RST_TRIM   = 23'd65536;
	localparam logic [16:0]        RST_PAD    = 17'd65536;
	localparam logic signed [30:0] RST_LPA_B0 = 31'sd175771537;
	localparam logic signed [30:0] RST_LPA_A1 = 31'sd336161721;
	localparam logic signed [30:0] RST_LPA_A2 = 31'sd98381594;
	localparam logic signed [30:0] RST_LPB_B0 = 31'sd219311768;
	localparam logic signed [30:0] RST_LPB_A1 = 31'sd419484087;
	localparam logic signed [30:0] RST_LPB_A2 = 31'sd189327528;

	typedef enum logic [2:0] {
		REG_TRIM   = 3'd0,
		REG_PAD    = 3'd1,
		REG_LPA_B0 = 3'd2,
		REG_LPA_A1 = 3'd3,
		REG_LPA_A2 = 3'd4,
		REG_LPB_B0 = 3'd5,
		REG_LPB_A1 = 3'd6,
		REG_LPB_A2 = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [22:0]        in_trim_gain;
		logic [16:0]        out_pad_gain;
		logic signed [30:0] lp_a_b0;
		logic signed [30:0] lp_a_a1;
		logic signed [30:0] lp_a_a2;
		logic signed [30:0] lp_b_b0;
		logic signed [30:0] lp_b_a1;
		logic signed [30:0] lp_b_a2;
	} cfg_t;

	// Microcode fields
	typedef enum logic [1:0] {
		SQ_NEXT,
		SQ_WAIT_IN,
		SQ_WAIT_OUT,
		SQ_GOTO
	} seq_t;

	typedef enum logic [3:0] {
		MA_NONE, MA_DHI, MA_DLO, MA_T,
		MA_AX1, MA_AX2, MA_AY1, MA_AY2,
		MA_BX1, MA_BX2, MA_BY1, MA_BY2,
		MA_Y, MA_P
	} ma_t;

	typedef enum logic [3:0] {
		MB_NONE, MB_HPF, MB_HPB, MB_TRIM, MB_PAD,
		MB_AB0, MB_AA1, MB_AA2, MB_BB0, MB_BA1, MB_BA2,
		MB_Y, MB_P, MB_SOFTK
	} mb_t;

	typedef enum logic [2:0] {
		ACC_HOLD, ACC_LD, ACC_LD_SH24, ACC_ADD,
		ACC_LD_R2, ACC_ADD_R2, ACC_ADD_R1, ACC_SUB_R2
	} acc_t;

	typedef enum logic [3:0] {
		WB_NONE, WB_D_FRONT, WB_AVGF, WB_T_HP16, WB_TRIM, WB_BQA,
		WB_P, WB_SOFT, WB_BQB, WB_D_BACK, WB_AVGB, WB_T_HP8
	} wb_t;

	typedef struct packed {
		seq_t            seq;
		logic [PC_W-1:0] tgt;
		ma_t             ma;
		mb_t             mb;
		acc_t            acc;
		wb_t             wb;
	} ctrl_t;

	typedef struct packed {
		logic in_fire;
		logic out_load;
	} hs_t;

	localparam logic [PC_W-1:0] STEP_IN = 6'd0;

	// Round half up, arithmetic shift right
	function automatic logic signed [ACC_W-1:0] rshr68(input logic signed [ACC_W-1:0] v,
		input int s);
		return (v + (68'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [31:0] r;
		if (v > 68'sd2147483647)
			r = 32'sh7FFF_FFFF;
		else if (v < -68'sd2147483648)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [ACC_W-1:0] v);
		logic signed [23:0] r;
		if (v > 68'sd8388607)
			r = 24'sh7F_FFFF;
		else if (v < -68'sd8388608)
			r = 24'sh80_0000;
		else
			r = v[23:0];
		return r;
	endfunction

	function automatic ctrl_t mk(input seq_t s, input logic [PC_W-1:0] t, input ma_t a,
		input mb_t b, input acc_t c, input wb_t w);
		ctrl_t r;
		r.seq = s;
		r.tgt = t;
		r.ma  = a;
		r.mb  = b;
		r.acc = c;
		r.wb  = w;
		return r;
	endfunction

	function automatic ctrl_t op(input ma_t a, input mb_t b, input acc_t c, input wb_t w);
		return mk(SQ_NEXT, STEP_IN, a, b, c, w);
	endfunction

	// Program. A multiply issued at a step is registered in the product register
	// and accumulated at the following step; the sum is read back from the accumulator register.
	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t w;
		case (pc)
			// front highpass
			6'd0:  w = mk(SQ_WAIT_IN, STEP_IN, MA_NONE, MB_NONE, ACC_HOLD, WB_NONE);
			6'd1:  w = op(MA_NONE, MB_NONE, ACC_HOLD,    WB_D_FRONT);
			6'd2:  w = op(MA_DHI,  MB_HPF,  ACC_HOLD,    WB_NONE);
			6'd3:  w = op(MA_DLO,  MB_HPF,  ACC_LD_SH24, WB_NONE);
			6'd4:  w = op(MA_NONE, MB_NONE, ACC_ADD,     WB_NONE);
			6'd5:  w = op(MA_NONE, MB_NONE, ACC_HOLD,    WB_AVGF);
			6'd6:  w = op(MA_NONE, MB_NONE, ACC_HOLD,    WB_D_FRONT);
			6'd7:  w = op(MA_NONE, MB_NONE, ACC_HOLD,    WB_T_HP16);
			// trim
			6'd8:  w = op(MA_T,    MB_TRIM, ACC_HOLD,    WB_NONE);
			6'd9:  w = op(MA_NONE, MB_NONE, ACC_LD,      WB_NONE);
			6'd10: w = op(MA_NONE, MB_NONE, ACC_HOLD,    WB_TRIM);
			// lowpass A and clip
			6'd11: w = op(MA_T,    MB_AB0,  ACC_HOLD,    WB_NONE);
			6'd12: w = op(MA_AX1,  MB_AB0,  ACC_LD_R2,   WB_NONE);
			6'd13: w = op(MA_AX2,  MB_AB0,  ACC_ADD_R1,  WB_NONE);
			6'd14: w = op(MA_AY1,  MB_AA1,  ACC_ADD_R2,  WB_NONE);
			6'd15: w = op(MA_AY2,  MB_AA2,  ACC_SUB_R2,  WB_NONE);
			6'd16: w = op(MA_NONE, MB_NONE, ACC_SUB_R2,  WB_NONE);
			6'd17: w = op(MA_NONE, MB_NONE, ACC_HOLD,    WB_BQA);
			// soft saturation
			6'd18: w = op(MA_Y,    MB_Y,    ACC_HOLD,    WB_NONE);
			6'd19: w = op(MA_NONE, MB_NONE, ACC_LD,      WB_NONE);
			6'd20: w = op(MA_NONE, MB_NONE, ACC_HOLD,    WB_P);
			6'd21: w = op(MA_P,    MB_P,    ACC_HOLD,    WB_NONE);
			6'd22: w = op(MA_NONE, MB_NONE, ACC_LD,      WB_NONE);
			6'd23: w = op(MA_NONE, MB_NONE, ACC_HOLD,    WB_P);
			6'd24: w = op(MA_P,    MB_Y,    ACC_HOLD,    WB_NONE);
			6'd25: w = op(MA_NONE, MB_NONE, ACC_LD,      WB_NONE);
			6'd26: w = op(MA_NONE, MB_NONE, ACC_HOLD,    WB_P);
			6'd27: w = op(MA_P,    MB_SOFTK, ACC_HOLD,   WB_NONE);
			6'd28: w = op(MA_NONE, MB_NONE, ACC_LD,      WB_NONE);
			6'd29: w = op(MA_NONE, MB_NONE, ACC_HOLD,    WB_SOFT);
			// lowpass B
			6'd30: w = op(MA_T,    MB_BB0,  ACC_HOLD,    WB_NONE);
			6'd31: w = op(MA_BX1,  MB_BB0,  ACC_LD_R2,   WB_NONE);
			6'd32: w = op(MA_BX2,  MB_BB0,  ACC_ADD_R1,  WB_NONE);
			6'd33: w = op(MA_BY1,  MB_BA1,  ACC_ADD_R2,  WB_NONE);
			6'd34: w = op(MA_BY2,  MB_BA2,  ACC_SUB_R2,  WB_NONE);
			6'd35: w = op(MA_NONE, MB_NONE, ACC_SUB_R2,  WB_NONE);
			6'd36: w = op(MA_NONE, MB_NONE, ACC_HOLD,    WB_BQB);
			// back highpass
			6'd37: w = op(MA_NONE, MB_NONE, ACC_HOLD,    WB_D_BACK);
			6'd38: w = op(MA_DHI,  MB_HPB,  ACC_HOLD,    WB_NONE);
			6'd39: w = op(MA_DLO,  MB_HPB,  ACC_LD_SH24, WB_NONE);
			6'd40: w = op(MA_NONE, MB_NONE, ACC_ADD,     WB_NONE);
			6'd41: w = op(MA_NONE, MB_NONE, ACC_HOLD,    WB_AVGB);
			6'd42: w = op(MA_NONE, MB_NONE, ACC_HOLD,    WB_D_BACK);
			6'd43: w = op(MA_NONE, MB_NONE, ACC_HOLD,    WB_T_HP8);
			// pad, then hand over to the output register
			6'd44: w = op(MA_T,    MB_PAD,  ACC_HOLD,    WB_NONE);
			6'd45: w = op(MA_NONE, MB_NONE, ACC_LD,      WB_NONE);
			6'd46: w = mk(SQ_WAIT_OUT, STEP_IN, MA_NONE, MB_NONE, ACC_HOLD, WB_NONE);
			default: w = mk(SQ_GOTO, STEP_IN, MA_NONE, MB_NONE, ACC_HOLD, WB_NONE);
		endcase
		return w;
	endfunction

endpackage

>>> design/console_input_stage_colorer.sv
// Top level of the console input stage colorer: stream ports, APB register port.
// Depends on cisc_pkg, cisc_cfg_regs, cisc_useq and cisc_datapath.
//
// One signed Q1.23 mono sample per input beat, one processed sample per output
// beat, in order, with tlast copied through. The chain is a leaky-average
// highpass, trim gain, biquad lowpass A, hard clip to +-1, the soft saturation
// x - 0.1768*x^5, biquad lowpass B, a second highpass and the output pad, with
// the result saturated to 24 bits. All arithmetic runs on a single 33x32-bit
// multiplier and a 68-bit accumulator, stepped by a 47-word microprogram; a
// sample goes through the whole program from its input beat to the load of
// the output register at its last step, and that step waits while the
// output register still holds a result that the sink has not taken yet.
// Input beats are taken only after that load. s_axis_tready
// is high only on the first step of the program, so one sample is in flight
// at a time; the finished sample sits in the output register while the next
// one is taken in. Highpass amounts are fixed for 44.1 kHz; the trim, pad and
// lowpass coefficients are APB registers at byte addresses 0x00..0x1C, reset
// to the 44.1 kHz design. Registers should only be written while no sample
// is in flight.
module console_input_stage_colorer (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [23:0] sample_in
	input  logic        s_axis_tlast,   // frame_last
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [23:0] sample_out
	output logic        m_axis_tlast,   // frame_last_out
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import cisc_pkg::*;

	cfg_t  cfg;
	ctrl_t cw;
	hs_t   hs;
	logic  out_free;
	logic signed [SAMPLE_W-1:0] out_sample;

	cisc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// program counter and control store
	cisc_useq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.out_free (out_free),
		.in_ready (s_axis_tready),
		.cw       (cw),
		.hs       (hs)
	);

	// shared multiplier, accumulator, filter state and output register
	cisc_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cw         (cw),
		.hs         (hs),
		.in_sample  ($signed(s_axis_tdata)),
		.in_last    (s_axis_tlast),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_sample (out_sample),
		.out_last   (m_axis_tlast),
		.out_free   (out_free)
	);

	assign m_axis_tdata = out_sample;

`ifndef ASSERT_OFF
	// the program leaves its input step as soon as a beat is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted on consecutive cycles");

	// a new result only appears after the program loaded the output register
	a_out_from_prog: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(hs.out_load))
		else $error("output valid rose without a program load");

	// after handing over a result the program is back at its input step
	a_back_to_input: assert property (@(posedge clk) disable iff (!arst_n)
		hs.out_load |=> s_axis_tready)
		else $error("sequencer did not return to input step");
`endif

endmodule

>>> design/cisc_cfg_regs.sv
// Configuration register bank with an APB-style write/read port.
// Depends on cisc_pkg for the register layout and reset values.
module cisc_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cisc_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output cisc_pkg::cfg_t               cfg
);
	import cisc_pkg::*;

	cfg_t     cfg_q;
	cfg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = cfg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_trim_gain <= RST_TRIM;
			cfg_q.out_pad_gain <= RST_PAD;
			cfg_q.lp_a_b0      <= RST_LPA_B0;
			cfg_q.lp_a_a1      <= RST_LPA_A1;
			cfg_q.lp_a_a2      <= RST_LPA_A2;
			cfg_q.lp_b_b0      <= RST_LPB_B0;
			cfg_q.lp_b_a1      <= RST_LPB_A1;
			cfg_q.lp_b_a2      <= RST_LPB_A2;
		end else if (wr_en) begin
			case (idx)
				REG_TRIM:   cfg_q.in_trim_gain <= pwdata[22:0];
				REG_PAD:    cfg_q.out_pad_gain <= pwdata[16:0];
				REG_LPA_B0: cfg_q.lp_a_b0      <= pwdata[30:0];
				REG_LPA_A1: cfg_q.lp_a_a1      <= pwdata[30:0];
				REG_LPA_A2: cfg_q.lp_a_a2      <= pwdata[30:0];
				REG_LPB_B0: cfg_q.lp_b_b0      <= pwdata[30:0];
				REG_LPB_A1: cfg_q.lp_b_a1      <= pwdata[30:0];
				REG_LPB_A2: cfg_q.lp_b_a2      <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_TRIM:   prdata = {9'd0, cfg_q.in_trim_gain};
			REG_PAD:    prdata = {15'd0, cfg_q.out_pad_gain};
			REG_LPA_B0: prdata = {1'b0, cfg_q.lp_a_b0};
			REG_LPA_A1: prdata = {1'b0, cfg_q.lp_a_a1};
			REG_LPA_A2: prdata = {1'b0, cfg_q.lp_a_a2};
			REG_LPB_B0: prdata = {1'b0, cfg_q.lp_b_b0};
			REG_LPB_A1: prdata = {1'b0, cfg_q.lp_b_a1};
			REG_LPB_A2: prdata = {1'b0, cfg_q.lp_b_a2};
			default:    prdata = 32'd0;
		endcase
	end

endmodule

>>> design/cisc_useq.sv
// Microcode sequencer: step counter, conditional jumps and registered control word.
// Depends on cisc_pkg for the control word layout and the program ROM.
module cisc_useq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_free,
	output logic            in_ready,
	output cisc_pkg::ctrl_t cw,
	output cisc_pkg::hs_t   hs
);
	import cisc_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_d;
	ctrl_t           cw_q;

	assign cw          = cw_q;
	assign in_ready    = (cw_q.seq == SQ_WAIT_IN);
	assign hs.in_fire  = (cw_q.seq == SQ_WAIT_IN) && in_valid;
	assign hs.out_load = (cw_q.seq == SQ_WAIT_OUT) && out_free;

	always_comb begin
		case (cw_q.seq)
			SQ_NEXT:     pc_d = pc_q + 1'b1;
			SQ_WAIT_IN:  pc_d = in_valid ? pc_q + 1'b1 : cw_q.tgt;
			SQ_WAIT_OUT: pc_d = out_free ? cw_q.tgt : pc_q;
			SQ_GOTO:     pc_d = cw_q.tgt;
			default:     pc_d = STEP_IN;
		endcase
	end

	// control word is fetched from the next step's address so the datapath sees it registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IN;
			cw_q <= ucode(STEP_IN);
		end else begin
			pc_q <= pc_d;
			cw_q <= ucode(pc_d);
		end
	end

endmodule

>>> design/cisc_datapath.sv
// Datapath: one shared multiplier, accumulator, filter state, temporaries and the
// output register. Driven by the control word from cisc_useq; depends on cisc_pkg.
module cisc_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cisc_pkg::cfg_t                    cfg,
	input  cisc_pkg::ctrl_t                   cw,
	input  cisc_pkg::hs_t                     hs,
	input  logic signed [cisc_pkg::SAMPLE_W-1:0] in_sample,
	input  logic                              in_last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [cisc_pkg::SAMPLE_W-1:0] out_sample,
	output logic                              out_last,
	output logic                              out_free
);
	import cisc_pkg::*;

	// sample in flight
	logic signed [SAMPLE_W-1:0] xin_q;
	logic                       last_q;

	// filter state
	logic signed [39:0] avgf_q, avgb_q;
	logic signed [31:0] ax1_q, ax2_q, ay1_q, ay2_q;
	logic signed [23:0] bx1_q, bx2_q;
	logic signed [31:0] by1_q, by2_q;

	// temporaries
	logic signed [40:0] d_q;
	logic signed [32:0] t_q;
	logic signed [24:0] y_q, p_q;

	// multiply / accumulate
	logic signed [MA_W-1:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q, prod_x;

	// output register
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic                       out_last_q;

	// write-back values
	logic signed [39:0]      x39, y31;
	logic signed [40:0]      d_front, d_back;
	logic signed [ACC_W-1:0] acc_r32, acc_r23, acc_r16, acc_bq, d_r16, d_r8;
	logic signed [31:0]      bq_y, trim_y;
	logic signed [24:0]      clip_y;
	logic signed [23:0]      soft_y, pad_y;

	always_comb begin
		case (cw.ma)
			MA_DHI:  mul_a = MA_W'($signed(d_q[40:24]));
			MA_DLO:  mul_a = MA_W'(d_q[23:0]);
			MA_T:    mul_a = t_q;
			MA_AX1:  mul_a = MA_W'(ax1_q);
			MA_AX2:  mul_a = MA_W'(ax2_q);
			MA_AY1:  mul_a = MA_W'(ay1_q);
			MA_AY2:  mul_a = MA_W'(ay2_q);
			MA_BX1:  mul_a = MA_W'(bx1_q);
			MA_BX2:  mul_a = MA_W'(bx2_q);
			MA_BY1:  mul_a = MA_W'(by1_q);
			MA_BY2:  mul_a = MA_W'(by2_q);
			MA_Y:    mul_a = MA_W'(y_q);
			MA_P:    mul_a = MA_W'(p_q);
			default: mul_a = '0;
		endcase
	end

	always_comb begin
		case (cw.mb)
			MB_HPF:   mul_b = HPF_FRONT_AMT;
			MB_HPB:   mul_b = HPF_BACK_AMT;
			MB_TRIM:  mul_b = MB_W'(cfg.in_trim_gain);
			MB_PAD:   mul_b = MB_W'(cfg.out_pad_gain);
			MB_AB0:   mul_b = MB_W'($signed(cfg.lp_a_b0));
			MB_AA1:   mul_b = MB_W'($signed(cfg.lp_a_a1));
			MB_AA2:   mul_b = MB_W'($signed(cfg.lp_a_a2));
			MB_BB0:   mul_b = MB_W'($signed(cfg.lp_b_b0));
			MB_BA1:   mul_b = MB_W'($signed(cfg.lp_b_a1));
			MB_BA2:   mul_b = MB_W'($signed(cfg.lp_b_a2));
			MB_Y:     mul_b = MB_W'(y_q);
			MB_P:     mul_b = MB_W'(p_q);
			MB_SOFTK: mul_b = SOFT_K;
			default:  mul_b = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	assign prod_x = ACC_W'(prod_q);

	always_ff @(posedge clk) begin
		case (cw.acc)
			ACC_LD:      acc_q <= prod_x;
			ACC_LD_SH24: acc_q <= prod_x <<< 24;
			ACC_ADD:     acc_q <= acc_q + prod_x;
			ACC_LD_R2:   acc_q <= rshr68(prod_x, 2);
			ACC_ADD_R2:  acc_q <= acc_q + rshr68(prod_x, 2);
			ACC_ADD_R1:  acc_q <= acc_q + rshr68(prod_x, 1);
			ACC_SUB_R2:  acc_q <= acc_q - rshr68(prod_x, 2);
			default:     acc_q <= acc_q;
		endcase
	end

	// values formed from the accumulator and the temporaries
	assign x39     = {xin_q, 16'd0};
	assign y31     = {t_q[31:0], 8'd0};
	assign d_front = 41'(x39) - 41'(avgf_q);
	assign d_back  = 41'(y31) - 41'(avgb_q);
	assign acc_r32 = rshr68(acc_q, 32);
	assign acc_r23 = rshr68(acc_q, 23);
	assign acc_r16 = rshr68(acc_q, 16);
	assign acc_bq  = rshr68(acc_q, COEF_FRAC_BITS - 2);
	assign d_r16   = rshr68(ACC_W'(d_q), 16);
	assign d_r8    = rshr68(ACC_W'(d_q), 8);
	assign bq_y    = sat32(acc_bq);
	assign trim_y  = sat32(acc_r16);
	assign pad_y   = sat24(acc_r16);
	assign soft_y  = sat24(ACC_W'(y_q) - acc_r32);

	// hard clip to +-1.0
	always_comb begin
		if (32'(bq_y) > 32'(ONE_Q23))
			clip_y = ONE_Q23;
		else if (32'(bq_y) < -32'(ONE_Q23))
			clip_y = -ONE_Q23;
		else
			clip_y = bq_y[24:0];
	end

	// temporaries: no reset needed
	always_ff @(posedge clk) begin
		if (hs.in_fire) begin
			xin_q  <= in_sample;
			last_q <= in_last;
		end
		case (cw.wb)
			WB_D_FRONT: d_q <= d_front;
			WB_D_BACK:  d_q <= d_back;
			WB_T_HP16:  t_q <= d_r16[32:0];
			WB_T_HP8:   t_q <= d_r8[32:0];
			WB_TRIM:    t_q <= 33'(trim_y);
			WB_SOFT:    t_q <= 33'(soft_y);
			WB_BQB:     t_q <= 33'(bq_y);
			WB_BQA:     y_q <= clip_y;
			WB_P:       p_q <= acc_r23[24:0];
			default: ;
		endcase
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avgf_q <= '0;
			avgb_q <= '0;
			ax1_q  <= '0;
			ax2_q  <= '0;
			ay1_q  <= '0;
			ay2_q  <= '0;
			bx1_q  <= '0;
			bx2_q  <= '0;
			by1_q  <= '0;
			by2_q  <= '0;
		end else begin
			case (cw.wb)
				WB_AVGF: avgf_q <= avgf_q + acc_r32[39:0];
				WB_AVGB: avgb_q <= avgb_q + acc_r32[39:0];
				WB_BQA: begin
					ax2_q <= ax1_q;
					ax1_q <= t_q[31:0];
					ay2_q <= ay1_q;
					ay1_q <= bq_y;
				end
				WB_BQB: begin
					bx2_q <= bx1_q;
					bx1_q <= t_q[23:0];
					by2_q <= by1_q;
					by1_q <= bq_y;
				end
				default: ;
			endcase
		end
	end

	// output register
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (hs.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (hs.out_load) begin
			out_sample_q <= pad_y;
			out_last_q   <= last_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;
	assign out_last   = out_last_q;

endmodule

>>> verif/console_input_stage_colorer_tb.sv
// Self-checking bench for console_input_stage_colorer: stream driver and monitor,
// an integer model of the filter chain, and APB register writes between phases.
// Depends on cisc_pkg (register index enum and COEF_FRAC_BITS) and the block's RTL.
`timescale 1ns / 100ps

module console_input_stage_colorer_tb;
	import cisc_pkg::*;

	// cycles with no beat on either side before the run is declared hung;
	// covers the long sink hold-off, the longest gaps and a config pass
	localparam int HANG_LIMIT = 5000;
	localparam int LONG_HOLD  = 500;
	localparam int SETTLE     = 60;   // a little over one pass of the microprogram
	localparam int MAX_NOTES  = 20;

	// fixed chain constants (Q0.32, unity in Q1.23)
	localparam longint HPF_IN_STEP  = 64'sd7992363;
	localparam longint HPF_OUT_STEP = 64'sd1234786;
	localparam longint SAT_K        = 64'sd759350218;
	localparam longint UNITY_Q23    = 64'sd8388608;

	typedef struct packed {
		logic [23:0] sample;
		logic        last;
	} sample_beat_t;

	logic clk;
	logic arst_n = 1'b0;

	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata  = '0;   // [23:0] sample_in
	logic        s_axis_tlast  = 1'b0; // frame_last
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;         // [23:0] sample_out
	logic        m_axis_tlast;         // frame_last_out
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [4:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;

	console_input_stage_colorer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// stimulus waiting to go out, and samples the chain should produce
	sample_beat_t sample_feed[$];
	sample_beat_t due_samples[$];

	// pacing knobs, set by the sequence between phases
	int src_idle_pct  = 0;
	int snk_stall_pct = 0;
	bit pressure_on   = 1'b0;
	int feed_gap      = 0;
	int sink_stall    = 0;
	int hold_done     = 0;
	int quiet_cycles  = 0;
	int fault_count   = 0;

	// model copy of the register file, reset to the 44.1 kHz design
	logic [22:0] trim_q = 23'd65536;
	logic [16:0] pad_q  = 17'd65536;
	longint lp_b0[2] = '{64'sd175771537, 64'sd219311768};
	longint lp_a1[2] = '{64'sd336161721, 64'sd419484087};
	longint lp_a2[2] = '{64'sd98381594,  64'sd189327528};

	// model filter state: [0] is lowpass A, [1] lowpass B
	longint hpf_in_avg  = 0;
	longint hpf_out_avg = 0;
	longint lp_xh[2][2] = '{'{0, 0}, '{0, 0}};
	longint lp_yh[2][2] = '{'{0, 0}, '{0, 0}};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// shift right rounding half up; done 66 bits wide so the bias cannot wrap
	function automatic longint rnd_shr(input longint v, input int s);
		logic signed [65:0] w;
		w = v;
		w = (w + (66'sd1 <<< (s - 1))) >>> s;
		return longint'(w[63:0]);
	endfunction

	function automatic longint clamp_bits(input longint v, input int bits);
		longint lim;
		lim = longint'(1) <<< (bits - 1);
		if (v > lim - 1)
			return lim - 1;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// DF1 biquad, feedforward b0/2b0/b0, products pre-shifted by 2 (1 for 2b0)
	function automatic longint lowpass_step(input longint x, input int f);
		longint acc;
		longint y;
		acc = rnd_shr(lp_b0[f] * x, 2) + rnd_shr(lp_b0[f] * lp_xh[f][0], 1)
			+ rnd_shr(lp_b0[f] * lp_xh[f][1], 2)
			- rnd_shr(lp_a1[f] * lp_yh[f][0], 2) - rnd_shr(lp_a2[f] * lp_yh[f][1], 2);
		y = clamp_bits(rnd_shr(acc, COEF_FRAC_BITS - 2), 32);
		lp_xh[f][1] = lp_xh[f][0];
		lp_xh[f][0] = x;
		lp_yh[f][1] = lp_yh[f][0];
		lp_yh[f][0] = y;
		return y;
	endfunction

	// whole chain for one accepted input beat
	function automatic sample_beat_t colour_sample(input logic [23:0] din, input logic last_in);
		sample_beat_t res;
		longint x39, t, y, p2, p4, p5, y31;
		// front highpass, Q1.39 leaky average
		x39 = longint'($signed(din)) * 65536;
		hpf_in_avg = hpf_in_avg + rnd_shr((x39 - hpf_in_avg) * HPF_IN_STEP, 32);
		t = rnd_shr(x39 - hpf_in_avg, 16);
		// trim
		t = clamp_bits(rnd_shr(t * longint'(trim_q), 16), 32);
		// lowpass A then hard clip to +-1
		y = lowpass_step(t, 0);
		if (y > UNITY_Q23)
			y = UNITY_Q23;
		if (y < -UNITY_Q23)
			y = -UNITY_Q23;
		// x - k*x^5
		p2 = rnd_shr(y * y, 23);
		p4 = rnd_shr(p2 * p2, 23);
		p5 = rnd_shr(p4 * y, 23);
		y = clamp_bits(y - rnd_shr(p5 * SAT_K, 32), 24);
		y = lowpass_step(y, 1);
		// back highpass in Q9.31
		y31 = y * 256;
		hpf_out_avg = hpf_out_avg + rnd_shr((y31 - hpf_out_avg) * HPF_OUT_STEP, 32);
		t = rnd_shr(y31 - hpf_out_avg, 8);
		t = clamp_bits(rnd_shr(t * longint'(pad_q), 16), 24);
		res.sample = t[23:0];
		res.last   = last_in;
		return res;
	endfunction

	// APB write: setup, access, register takes the value at the access edge
	task automatic cfg_write(input cfg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_TRIM:   trim_q   = val[22:0];
			REG_PAD:    pad_q    = val[16:0];
			REG_LPA_B0: lp_b0[0] = longint'($signed(val[30:0]));
			REG_LPA_A1: lp_a1[0] = longint'($signed(val[30:0]));
			REG_LPA_A2: lp_a2[0] = longint'($signed(val[30:0]));
			REG_LPB_B0: lp_b0[1] = longint'($signed(val[30:0]));
			REG_LPB_A1: lp_a1[1] = longint'($signed(val[30:0]));
			REG_LPB_A2: lp_a2[1] = longint'($signed(val[30:0]));
			default: ;
		endcase
	endtask

	task automatic load_settings(input logic [31:0] trim, input logic [31:0] pad,
		input logic [31:0] ab0, input logic [31:0] aa1, input logic [31:0] aa2,
		input logic [31:0] bb0, input logic [31:0] ba1, input logic [31:0] ba2);
		cfg_write(REG_TRIM, trim);
		cfg_write(REG_PAD, pad);
		cfg_write(REG_LPA_B0, ab0);
		cfg_write(REG_LPA_A1, aa1);
		cfg_write(REG_LPA_A2, aa2);
		cfg_write(REG_LPB_B0, bb0);
		cfg_write(REG_LPB_A1, ba1);
		cfg_write(REG_LPB_A2, ba2);
	endtask

	// amplitude mix: mostly full scale noise, some quiet passages and rails
	function automatic logic [23:0] pick_sample();
		logic [31:0] r;
		logic [23:0] v;
		r = $urandom;
		case ($urandom_range(9))
			5, 6:    v = {{12{r[11]}}, r[11:0]};
			7:       v = 24'h7F_FFFF;
			8:       v = 24'h80_0000;
			9:       v = {{6{r[17]}}, r[17:0]};
			default: v = r[23:0];
		endcase
		return v;
	endfunction

	// wait until every sample has gone through, then let the engine settle
	task automatic drain();
		do
			@(posedge clk);
		while (sample_feed.size() != 0 || s_axis_tvalid || due_samples.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic run_phase(input int n, input int src_pct, input int snk_pct);
		sample_beat_t b;
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
		repeat (n) begin
			b.sample = pick_sample();
			b.last   = ($urandom_range(7) == 0);
			sample_feed.push_back(b);
		end
		drain();
	endtask

	// Input side. The model is stepped at the accepting edge, so the store of
	// due samples is always in acceptance order. Gaps come in bursts so that
	// tvalid rises at any point of the 47-step program.
	always @(posedge clk) begin : feed_drive
		sample_beat_t nxt;
		if (s_axis_tvalid && s_axis_tready)
			due_samples.push_back(colour_sample(s_axis_tdata, s_axis_tlast));
		if (!s_axis_tvalid || s_axis_tready) begin
			if (feed_gap > 0) begin
				feed_gap      <= feed_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (sample_feed.size() != 0 && $urandom_range(99) < src_idle_pct) begin
				feed_gap      <= ($urandom_range(3) == 0) ? $urandom_range(10, 100)
					: $urandom_range(0, 4);
				s_axis_tvalid <= 1'b0;
			end else if (sample_feed.size() != 0) begin
				nxt           = sample_feed.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= nxt.sample;
				s_axis_tlast  <= nxt.last;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Output side: compare against the oldest due sample, then pick tready.
	// The one long hold-off lets the output register and the engine both
	// fill while the driver keeps offering.
	always @(posedge clk) begin : out_check
		sample_beat_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (due_samples.size() == 0) begin
				fault_count++;
				if (fault_count <= MAX_NOTES)
					$display("%0t: output beat with nothing due, got sample %h last %b",
						$time, m_axis_tdata, m_axis_tlast);
			end else begin
				want = due_samples.pop_front();
				if (m_axis_tdata !== want.sample) begin
					fault_count++;
					if (fault_count <= MAX_NOTES)
						$display("%0t: sample_out expected %h got %h",
							$time, want.sample, m_axis_tdata);
				end
				if (m_axis_tlast !== want.last) begin
					fault_count++;
					if (fault_count <= MAX_NOTES)
						$display("%0t: frame_last_out expected %b got %b",
							$time, want.last, m_axis_tlast);
				end
			end
		end
		if (pressure_on && hold_done < LONG_HOLD) begin
			m_axis_tready <= 1'b0;
			hold_done     <= hold_done + 1;
		end else if (sink_stall > 0) begin
			m_axis_tready <= 1'b0;
			sink_stall    <= sink_stall - 1;
		end else if ($urandom_range(99) < snk_stall_pct) begin
			m_axis_tready <= 1'b0;
			sink_stall    <= ($urandom_range(3) == 0) ? $urandom_range(20, 120)
				: $urandom_range(0, 3);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// hang detector: no beat on either stream for too long
	always @(posedge clk) begin : hang_watch
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= HANG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : sequence_main
		sample_beat_t b;
		logic [23:0] directed[$];
		directed = '{24'h00_0000, 24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF, 24'h7F_FFFF,
			24'h7F_FFFF, 24'h80_0000, 24'h80_0000, 24'h80_0000, 24'h00_0001,
			24'hFF_FFFF, 24'h40_0000, 24'hC0_0000, 24'h55_5555, 24'hAA_AAAA,
			24'h00_0FFF, 24'hFF_F000, 24'h00_0000, 24'h00_0000, 24'h7F_FFFF};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset coefficients untouched: rails, DC steps and bit patterns, tlast both ways
		foreach (directed[i]) begin
			b.sample = directed[i];
			b.last   = i[0];
			sample_feed.push_back(b);
		end
		drain();
		run_phase(60, 0, 0);

		// trim at its top: lowpass A runs into the clip
		load_settings(32'd6553600, 32'd65536, 32'd175771537, 32'd336161721, 32'd98381594,
			32'd219311768, 32'd419484087, 32'd189327528);
		run_phase(60, 50, 0);

		// both gains beyond their ranges, output saturates
		load_settings(32'h007F_FFFF, 32'h0001_FFFF, 32'd175771537, 32'd336161721,
			32'd98381594, 32'd219311768, 32'd419484087, 32'd189327528);
		run_phase(60, 0, 50);

		// zero gains: silence out, state still moves
		load_settings(32'd0, 32'd0, 32'd175771537, 32'd336161721, 32'd98381594,
			32'd219311768, 32'd419484087, 32'd189327528);
		run_phase(30, 36, 36);

		// arbitrary coefficient patterns, likely unstable and stuck at the rails
		load_settings($urandom_range(6553600), $urandom_range(65536), $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom);
		run_phase(60, 36, 36);

		// coefficient extremes
		load_settings(32'd65536, 32'd65536, 32'h4000_0000, 32'h3FFF_FFFF, 32'h4000_0000,
			32'h3FFF_FFFF, 32'h4000_0000, 32'h3FFF_FFFF);
		run_phase(40, 36, 36);

		// back to the design, mild drive; sink holds off long to back the block up
		load_settings(32'd262144, 32'd32768, 32'd175771537, 32'd336161721, 32'd98381594,
			32'd219311768, 32'd419484087, 32'd189327528);
		pressure_on = 1'b1;
		run_phase(60, 0, 0);

		if (fault_count == 0 && due_samples.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
